[rtl/steim1_frame_decoder_macros.svh]
// ---------------------------------------------------------------------------
// Steim1 frame decoder assertion macros
// Shared concurrent assertion forms for the decoder RTL.
// ---------------------------------------------------------------------------
`ifndef STEIM1_FRAME_DECODER_MACROS_SVH
`define STEIM1_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STFD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/stfd_pkg.sv]
// ---------------------------------------------------------------------------
// stfd_pkg
// Types and constants shared by the Steim1 frame decoder modules.
// ---------------------------------------------------------------------------
package stfd_pkg;

    localparam int WORD_BITS       = 32;
    localparam int WORDS_PER_FRAME = 16;
    localparam int POS_BITS        = $clog2(WORDS_PER_FRAME);
    localparam int IN_COUNT_BITS   = 16;
    localparam int QUEUE_DEPTH     = 2;

    // Control word: code of frame word w sits at bits CTRL_TOP_SHIFT-2w +: 2
    localparam logic [4:0] CTRL_TOP_SHIFT = 5'd30;
    localparam logic [4:0] BYTE_TOP_SHIFT = 5'd24;

    localparam logic [1:0] CODE_SKIP   = 2'd0;
    localparam logic [1:0] CODE_BYTES  = 2'd1;
    localparam logic [1:0] CODE_HALVES = 2'd2;
    localparam logic [1:0] CODE_WORD   = 2'd3;

    localparam logic ENC_RAW   = 1'b0;
    localparam logic ENC_STEIM = 1'b1;

    typedef enum logic [1:0] {
        CMD_RAW,    // emit the word, running value untouched
        CMD_X0,     // load running value with the word and emit it
        CMD_DIFF    // add packed differences to the running value
    } cmd_kind_t;

    typedef enum logic [1:0] {
        DW_BYTE,
        DW_HALF,
        DW_WORD
    } diff_width_t;

    typedef struct packed {
        cmd_kind_t       kind;
        diff_width_t     width;
        logic [31:0]     word;
        logic [1:0]      first_idx;   // index of first difference to use
        logic [2:0]      num;         // samples to emit, 1..4
        logic            done;        // last emitted sample ends the record
    } cmd_t;

    typedef struct packed {
        logic        full;
        logic        empty;
    } queue_status_t;

    typedef struct packed {
        logic [31:0] data_word;
        logic        new_record;
        logic [15:0] record_samples;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               last_of_run;
        logic               record_done;
    } out_item_t;

endpackage

[rtl/stfd_front.sv]
// ---------------------------------------------------------------------------
// stfd_front
// Accepts data words, tracks frame position and sample count, and turns
// each word that yields samples into a command for the sample back end.
// ---------------------------------------------------------------------------
module stfd_front #(
    parameter int COUNT_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic                    cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  stfd_pkg::in_item_t      s_data,
    input  stfd_pkg::queue_status_t q_status,
    output logic                    push,
    output stfd_pkg::cmd_t          push_cmd
);
    import stfd_pkg::*;

    logic                  mode_reg;
    logic [31:0]           ctrl_reg, ctrl_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [COUNT_BITS-1:0] left_reg, left_next;
    logic                  first_frame_reg, first_frame_next;
    logic                  skip_reg, skip_next;

    logic                          accept;
    logic [COUNT_BITS+IN_COUNT_BITS-1:0] count_wide;
    logic [COUNT_BITS-1:0]         count_load;
    logic [COUNT_BITS-1:0]         left_eff;
    logic [POS_BITS-1:0]           pos_eff;
    logic                          first_eff;
    logic                          skip_eff;
    logic [4:0]                    code_shift;
    logic [1:0]                    code;
    logic [2:0]                    diff_cnt;
    logic [2:0]                    avail;
    logic [2:0]                    num;
    logic                          emit;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    assign count_wide = {{COUNT_BITS{1'b0}}, s_data.record_samples};
    assign count_load = count_wide[COUNT_BITS-1:0];

    always_comb begin
        left_eff  = s_data.new_record ? count_load : left_reg;
        pos_eff   = s_data.new_record ? '0 : pos_reg;
        first_eff = s_data.new_record ? 1'b1 : first_frame_reg;
        skip_eff  = s_data.new_record ? 1'b0 : skip_reg;

        code_shift = CTRL_TOP_SHIFT - {pos_eff, 1'b0};
        code       = 2'(ctrl_reg >> code_shift);

        case (code)
            CODE_BYTES:  diff_cnt = 3'd4;
            CODE_HALVES: diff_cnt = 3'd2;
            CODE_WORD:   diff_cnt = 3'd1;
            default:     diff_cnt = 3'd0;
        endcase
        avail = (diff_cnt != 3'd0 && skip_eff) ? diff_cnt - 3'd1 : diff_cnt;
        num   = (left_eff < COUNT_BITS'(avail)) ? left_eff[2:0] : avail;

        ctrl_next        = ctrl_reg;
        pos_next         = pos_eff;
        left_next        = left_eff;
        first_frame_next = first_eff;
        skip_next        = skip_eff;
        emit             = 1'b0;

        push_cmd.kind      = CMD_DIFF;
        push_cmd.width     = DW_WORD;
        push_cmd.word      = s_data.data_word;
        push_cmd.first_idx = {1'b0, skip_eff};
        push_cmd.num       = num;
        push_cmd.done      = (left_eff == COUNT_BITS'(num));

        case (code)
            CODE_BYTES:  push_cmd.width = DW_BYTE;
            CODE_HALVES: push_cmd.width = DW_HALF;
            default:     push_cmd.width = DW_WORD;
        endcase

        if (left_eff != '0) begin
            if (mode_reg == ENC_RAW) begin
                emit           = 1'b1;
                push_cmd.kind  = CMD_RAW;
                push_cmd.num   = 3'd1;
                push_cmd.done  = (left_eff == COUNT_BITS'(1));
                left_next      = left_eff - COUNT_BITS'(1);
            end else begin
                pos_next = pos_eff + POS_BITS'(1);
                if (pos_next == '0) begin
                    first_frame_next = 1'b0;
                end
                if (pos_eff == '0) begin
                    ctrl_next = s_data.data_word;
                end else if (first_eff && pos_eff == POS_BITS'(1)) begin
                    emit          = 1'b1;
                    push_cmd.kind = CMD_X0;
                    push_cmd.num  = 3'd1;
                    push_cmd.done = (left_eff == COUNT_BITS'(1));
                    left_next     = left_eff - COUNT_BITS'(1);
                    skip_next     = 1'b1;
                end else if (first_eff && pos_eff == POS_BITS'(2)) begin
                    // word 2 of the first frame carries the last sample: drop
                end else begin
                    if (diff_cnt != 3'd0) begin
                        skip_next = 1'b0;
                    end
                    emit      = (num != 3'd0);
                    left_next = left_eff - COUNT_BITS'(num);
                end
            end
        end
    end

    assign push = accept && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= ENC_STEIM;
            ctrl_reg        <= '0;
            pos_reg         <= '0;
            left_reg        <= '0;
            first_frame_reg <= 1'b0;
            skip_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            if (accept) begin
                ctrl_reg        <= ctrl_next;
                pos_reg         <= pos_next;
                left_reg        <= left_next;
                first_frame_reg <= first_frame_next;
                skip_reg        <= skip_next;
            end
        end
    end

endmodule

[rtl/stfd_queue.sv]
// ---------------------------------------------------------------------------
// stfd_queue
// Short command queue between the word front end and the sample back end.
// ---------------------------------------------------------------------------
module stfd_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  stfd_pkg::cmd_t          push_cmd,
    input  logic                    pop,
    output stfd_pkg::cmd_t          head_cmd,
    output stfd_pkg::queue_status_t status
);
    import stfd_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    cmd_t                mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    assign status.full  = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_cmd     = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                        : wr_ptr_reg + PTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                        : rd_ptr_reg + PTR_BITS'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_BITS'(1);
                2'b01:   count_reg <= count_reg - CNT_BITS'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[rtl/stfd_back.sv]
// ---------------------------------------------------------------------------
// stfd_back
// Executes queued commands: extracts differences, keeps the running value
// and emits one sample per cycle to the output register while not stalled.
// ---------------------------------------------------------------------------
module stfd_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  stfd_pkg::cmd_t          head_cmd,
    input  stfd_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output stfd_pkg::out_item_t     m_data
);
    import stfd_pkg::*;

    logic [31:0] run_reg, run_next;
    logic [1:0]  emit_cnt_reg;
    logic        m_valid_reg;
    out_item_t   m_data_reg;

    logic        fire;
    logic [1:0]  idx;
    logic        last;
    logic [31:0] diff;
    logic [31:0] value;
    logic [7:0]  byte_sel;
    logic [15:0] half_sel;

    assign fire = !q_status.empty && (!m_valid_reg || m_ready);
    assign idx  = head_cmd.first_idx + emit_cnt_reg;
    assign last = ({1'b0, emit_cnt_reg} + 3'd1 == head_cmd.num);
    assign pop  = fire && last;

    always_comb begin
        byte_sel = 8'(head_cmd.word >> (BYTE_TOP_SHIFT - {idx, 3'b000}));
        half_sel = idx[0] ? head_cmd.word[15:0] : head_cmd.word[31:16];
        case (head_cmd.width)
            DW_BYTE: diff = {{24{byte_sel[7]}}, byte_sel};
            DW_HALF: diff = {{16{half_sel[15]}}, half_sel};
            default: diff = head_cmd.word;
        endcase

        case (head_cmd.kind)
            CMD_DIFF: begin
                value    = run_reg + diff;
                run_next = value;
            end
            CMD_X0: begin
                value    = head_cmd.word;
                run_next = head_cmd.word;
            end
            default: begin
                value    = head_cmd.word;
                run_next = run_reg;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg.sample      <= value;
            m_data_reg.last_of_run <= last;
            m_data_reg.record_done <= last && head_cmd.done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg      <= '0;
            emit_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (fire) begin
                run_reg      <= run_next;
                emit_cnt_reg <= last ? 2'd0 : emit_cnt_reg + 2'd1;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

endmodule

[rtl/steim1_frame_decoder.sv]
// ---------------------------------------------------------------------------
// steim1_frame_decoder
// Decodes a record's data area, Steim1 frames or raw 32-bit samples.
// ---------------------------------------------------------------------------
// Usage:
//   s_* is the word channel (valid/ready). Each transfer carries one 32-bit
//   data word; new_record marks the first word of a record and brings its
//   sample count in record_samples.
//   m_* is the sample channel (valid/ready). Each transfer carries one
//   decoded sample, last_of_run on the final sample of an input word and
//   record_done on the record's final sample.
//   cfg_we/cfg_wdata write encoding_mode (0 raw, 1 Steim1); write it only
//   while the block is idle.
// Path: an accepted word's command is written into the queue, then its first
//   sample is registered in the output register before it reaches m_*.
// Throughput: one sample per cycle while m_ready is high, set by the single
//   output register of the back end; a byte word yields up to four samples,
//   a halfword word up to two, every other word one sample or none.
// Reset: synchronous, active low; empties the command queue, drops any
//   pending output, selects Steim1 mode and ignores words until a record
//   starts.
// Stall: when m_ready is low the output holds, the back end stops, and the
//   two-entry queue fills before s_ready drops.
// ---------------------------------------------------------------------------
`include "steim1_frame_decoder_macros.svh"

module steim1_frame_decoder #(
    parameter int COUNT_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  stfd_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output stfd_pkg::out_item_t m_data
);
    import stfd_pkg::*;

    // Front end -> queue
    logic          push;
    cmd_t          push_cmd;
    // Queue -> back end
    cmd_t          head_cmd;
    logic          pop;
    queue_status_t q_status;

    // Classify words and track frame position and remaining count.
    stfd_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // Hold commands so the word side keeps moving while samples drain.
    stfd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    // Expand commands into samples, one per cycle unless the output stalls.
    stfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_status (q_status),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // A command is never written into a full queue.
    `STFD_ASSERT_IMPLIES(a_no_push_full, aclk, aresetn, push, !q_status.full,
        "command pushed into full queue")

    // Every queued command emits at least one and at most four samples.
    `STFD_ASSERT_IMPLIES(a_push_num, aclk, aresetn, push,
        push_cmd.num != 3'd0 && push_cmd.num <= 3'd4, "command sample count out of range")

    // The record's final sample always closes its word's run.
    `STFD_ASSERT_IMPLIES(a_done_last, aclk, aresetn, m_valid && m_data.record_done,
        m_data.last_of_run, "record_done without last_of_run")

    // A pop without a push frees the head slot: the queue cannot be full right after.
    `STFD_ASSERT_NEXT(a_pop_frees, aclk, aresetn, pop && !push, !q_status.full,
        "queue still full after pop")

endmodule

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// Steim1 frame decoder testbench
// Streams record data words into the decoder and compares every sample on
// the output channel with a cycle-free decoder model kept in the bench.
// Covers raw and Steim1 mode, mode changes inside a record, and
// back-pressure from a stalling receiver.
// ---------------------------------------------------------------------------
module testbench;

    import stfd_pkg::*;

    localparam int SETTLE_CYCLES = 16;    // block latency plus queue, with margin
    localparam int STALL_LIMIT   = 2000;  // cycles without any transfer
    localparam int PRESSURE_HOLD = 200;   // long receiver hold-off
    localparam int PHASE_WORDS   = 26;    // minimum words per random phase
    localparam int MAX_PRINTS    = 50;

    typedef enum logic [1:0] {
        RX_OPEN,     // always ready
        RX_COIN,     // ready half the time
        RX_SPARSE,   // occasional stall
        RX_TOGGLE    // ready toggles high and low
    } rx_style_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;

    // Words waiting to be sent; the head is the one on the bus while s_valid.
    in_item_t    pending_words[$];
    // Samples the decoder model says must come out, oldest first.
    out_item_t   expected_samples[$];

    int          words_queued = 0;
    int          words_taken  = 0;
    int          idle_cycles  = 0;
    int          error_count  = 0;
    bit          s_took       = 1'b0;

    // Decoder model state
    logic                dec_mode;
    logic [31:0]         ctrl_word;
    logic [POS_BITS-1:0] frame_pos;
    logic [15:0]         samples_due;
    logic [31:0]         running_sum;
    logic                in_first_frame;
    logic                drop_next_diff;

    steim1_frame_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // -----------------------------------------------------------------------
    // Decoder model
    // -----------------------------------------------------------------------
    task automatic reset_decoder();
        dec_mode       = ENC_STEIM;
        ctrl_word      = '0;
        frame_pos      = '0;
        samples_due    = '0;
        running_sum    = '0;
        in_first_frame = 1'b0;
        drop_next_diff = 1'b0;
    endtask

    // Work out the samples that one accepted word produces and queue them.
    task automatic decode_word(input in_item_t w);
        logic [POS_BITS-1:0] pos;
        logic                first;
        logic [1:0]          code;
        logic [7:0]          byte_diff;
        logic [15:0]         half_diff;
        logic [31:0]         step;
        out_item_t           run [4];
        int                  cnt;
        int                  n;
        int                  k;

        n = 0;
        // A record start restarts the frame and reloads the count.
        if (w.new_record) begin
            samples_due    = w.record_samples;
            frame_pos      = '0;
            in_first_frame = 1'b1;
            drop_next_diff = 1'b0;
        end
        // No record open, or the count is used up: ignore the word.
        if (samples_due == 0)
            return;

        if (dec_mode == ENC_RAW) begin
            samples_due--;
            run[0].sample      = w.data_word;
            run[0].last_of_run = 1'b1;
            run[0].record_done = (samples_due == 0);
            expected_samples.push_back(run[0]);
            return;
        end

        pos       = frame_pos;
        first     = in_first_frame;
        frame_pos = frame_pos + 1'b1;
        if (frame_pos == 0)
            in_first_frame = 1'b0;

        if (pos == 0) begin
            ctrl_word = w.data_word;
            return;
        end
        // First frame: word 1 is the seed sample, word 2 is ignored.
        if (first && pos == 1) begin
            running_sum    = w.data_word;
            drop_next_diff = 1'b1;
            samples_due--;
            run[0].sample      = running_sum;
            run[0].last_of_run = 1'b1;
            run[0].record_done = (samples_due == 0);
            expected_samples.push_back(run[0]);
            return;
        end
        if (first && pos == 2)
            return;

        code = 2'(ctrl_word >> (int'(CTRL_TOP_SHIFT) - 2 * int'(pos)));
        case (code)
            CODE_BYTES:  cnt = 4;
            CODE_HALVES: cnt = 2;
            CODE_WORD:   cnt = 1;
            default:     cnt = 0;
        endcase

        for (k = 0; k < cnt && samples_due > 0; k++) begin
            case (code)
                CODE_BYTES: begin
                    byte_diff = 8'(w.data_word >> (int'(BYTE_TOP_SHIFT) - 8 * k));
                    step      = {{24{byte_diff[7]}}, byte_diff};
                end
                CODE_HALVES: begin
                    half_diff = 16'(w.data_word >> (16 - 16 * k));
                    step      = {{16{half_diff[15]}}, half_diff};
                end
                default: step = w.data_word;
            endcase
            // The difference right after the seed belongs to the previous record.
            if (drop_next_diff) begin
                drop_next_diff = 1'b0;
                continue;
            end
            running_sum = running_sum + step;
            samples_due--;
            run[n].sample      = running_sum;
            run[n].last_of_run = 1'b0;
            run[n].record_done = (samples_due == 0);
            n++;
        end
        if (n > 0)
            run[n-1].last_of_run = 1'b1;
        for (k = 0; k < n; k++)
            expected_samples.push_back(run[k]);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_PRINTS)
            $display("mismatch: %s got %h want %h", what, got, want);
        error_count++;
    endtask

    // -----------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge, predict on every
    // word transfer and check every sample transfer against the oldest
    // expectation.
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        out_item_t want;

        s_took = 1'b0;
        if (!aresetn) begin
            reset_decoder();
        end else begin
            // Track the mode register exactly where the block latches it.
            if (cfg_we)
                dec_mode = cfg_wdata;
            if (s_valid && s_ready) begin
                s_took = 1'b1;
                words_taken++;
                decode_word(s_data);
            end
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch("sample with none expected", m_data.sample, '0);
                end else begin
                    want = expected_samples.pop_front();
                    if (m_data.sample !== want.sample)
                        report_mismatch("sample", m_data.sample, want.sample);
                    if (m_data.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 32'(m_data.last_of_run),
                                        32'(want.last_of_run));
                    if (m_data.record_done !== want.record_done)
                        report_mismatch("record_done", 32'(m_data.record_done),
                                        32'(want.record_done));
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    // -----------------------------------------------------------------------
    // Sender: offer words in bursts with gaps between them. Hold valid and
    // payload until the transfer, then advance to the next queued word.
    // -----------------------------------------------------------------------
    int burst_left = 8;
    int gap_left   = 0;

    always @(negedge aclk) begin : sender
        logic     offer;

        offer = s_valid;
        if (s_took) begin
            void'(pending_words.pop_front());
            offer = 1'b0;
            if (burst_left > 0)
                burst_left--;
            // End of burst: pick the next burst length and the gap before it.
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
        end
        if (!offer) begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_words.size() > 0)
                offer = 1'b1;
        end
        s_valid <= offer;
        if (offer)
            s_data <= pending_words[0];
    end

    // -----------------------------------------------------------------------
    // Receiver: stall on a changing pattern. Once, after some words have gone
    // in, hold off for a long stretch so the block fills and drops s_ready.
    // -----------------------------------------------------------------------
    rx_style_t rx_style   = RX_OPEN;
    int        style_left = 0;
    int        hold_left  = 0;
    bit        hold_done  = 1'b0;
    bit        toggle     = 1'b0;

    always @(negedge aclk) begin : receiver
        if (!hold_done && words_taken >= 30) begin
            hold_left = PRESSURE_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                rx_style   = rx_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(16, 80);
            end
            style_left--;
            toggle = ~toggle;
            case (rx_style)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) != 0);
                default:   m_ready <= toggle;
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: end the run when nothing transfers for too long.
    // -----------------------------------------------------------------------
    initial begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("testbench: errors");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    task automatic queue_word(input logic [31:0] data, input logic start,
                              input logic [15:0] count);
        in_item_t w;
        w.data_word      = data;
        w.new_record     = start;
        w.record_samples = count;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Block until every word has gone in and every sample has come out,
    // then let the block run dry.
    task automatic wait_idle();
        while (pending_words.size() != 0 || s_valid || expected_samples.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_mode(input logic mode);
        wait_idle();
        cfg_wdata <= mode;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Well-formed Steim1 record of one to three frames with random content;
    // now and then cut short anywhere.
    task automatic queue_steim_record();
        int count;
        int total;
        int n;
        count = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(1, 48);
        total = 16 * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0)
            total = $urandom_range(1, total);
        queue_word($urandom, 1'b1, count[15:0]);
        for (n = 1; n < total; n++)
            queue_word($urandom, 1'b0, 16'($urandom_range(0, 65535)));
    endtask

    // Raw record: a few words past the count, or cut short.
    task automatic queue_raw_record();
        int count;
        int total;
        int n;
        count = $urandom_range(0, 24);
        total = count + $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            total = $urandom_range(1, total + 1);
        if (total == 0)
            total = 1;
        queue_word($urandom, 1'b1, count[15:0]);
        for (n = 1; n < total; n++)
            queue_word($urandom, 1'b0, 16'($urandom_range(0, 65535)));
    endtask

    initial begin : stimulus
        int   ph;
        int   target;
        logic mode;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- Directed: Steim1 special cases -------------------------------
        set_mode(ENC_STEIM);
        // Words before any record start are ignored.
        queue_word(32'hFFFF_FFFF, 1'b0, 16'hFFFF);
        // A record with count zero yields nothing, nor do the words after it.
        queue_word(32'h0000_0000, 1'b1, 16'h0000);
        queue_word(32'h1234_5678, 1'b0, 16'h0000);
        // Count 5; control codes on words 0..2 are set but must be ignored.
        // Word 3 bytes, word 4 halves (count runs out halfway), word 5 ignored.
        queue_word(32'hFDB0_0000, 1'b1, 16'd5);
        queue_word(32'h8000_0000, 1'b0, 16'h0000);   // seed, most negative
        queue_word(32'hFFFF_FFFF, 1'b0, 16'h0000);   // last-sample word, ignored
        queue_word(32'h7F80_01FF, 1'b0, 16'h0000);   // first byte dropped
        queue_word(32'h8000_7FFF, 1'b0, 16'h0000);
        queue_word(32'h0000_0001, 1'b0, 16'h0000);
        // New record mid-frame with the widest count; a single word
        // difference right after the seed is dropped and gives nothing.
        queue_word(32'h036C_6FFF, 1'b1, 16'hFFFF);
        queue_word(32'h7FFF_FFFF, 1'b0, 16'h0000);   // seed, most positive
        queue_word(32'h0000_0000, 1'b0, 16'h0000);
        queue_word(32'h0000_0001, 1'b0, 16'h0000);
        queue_word(32'h8080_8080, 1'b0, 16'h0000);   // four byte differences
        queue_word(32'hFFFF_0001, 1'b0, 16'h0000);   // two halfword differences

        // Switch to raw inside the record: every word is a sample and the
        // frame position stays where it was.
        set_mode(ENC_RAW);
        queue_word(32'hFFFF_FFFF, 1'b0, 16'h0000);
        queue_word(32'h0000_0000, 1'b0, 16'h0000);

        // Back to Steim1: resume at frame word 6.
        set_mode(ENC_STEIM);
        queue_word(32'hDEAD_BEEF, 1'b0, 16'h0000);   // word difference
        queue_word(32'h0123_4567, 1'b0, 16'h0000);   // skip code
        queue_word(32'h7F7F_7F7F, 1'b0, 16'h0000);   // byte differences
        queue_word(32'h7FFF_8000, 1'b0, 16'h0000);   // halfword differences

        // Raw record of three samples; the fourth word is past the count.
        set_mode(ENC_RAW);
        queue_word(32'h0000_0000, 1'b1, 16'd3);
        queue_word(32'hFFFF_FFFF, 1'b0, 16'hFFFF);
        queue_word(32'h8000_0000, 1'b0, 16'h0000);
        queue_word(32'h7FFF_FFFF, 1'b0, 16'h0000);

        // --- Random phases -------------------------------------------------
        for (ph = 0; ph < 6; ph++) begin
            mode = (ph % 3 == 1) ? ENC_RAW : ENC_STEIM;
            set_mode(mode);
            target = words_queued + PHASE_WORDS;
            while (words_queued < target) begin
                if ($urandom_range(0, 9) == 0)
                    queue_word($urandom, ($urandom_range(0, 3) == 0),
                               16'($urandom_range(0, 65535)));
                else if (mode == ENC_STEIM)
                    queue_steim_record();
                else
                    queue_raw_record();
            end
        end

        wait_idle();
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

[steim1_frame_decoder.f]
+incdir+rtl
rtl/stfd_pkg.sv
rtl/stfd_front.sv
rtl/stfd_queue.sv
rtl/stfd_back.sv
rtl/steim1_frame_decoder.sv
tb/testbench.sv
